// File: src/wbps_pkg.sv
package wbps_pkg;

    // signature geometry
    localparam int SIG_BYTES     = 16;
    localparam int LEN_W         = 5;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int OFFSET_OUT_W  = 32;

    // defaults for the top level parameters
    localparam int MAX_PATTERN_DEFAULT = 16;
    localparam int OFFSET_BITS_DEFAULT = 32;

    // register indexes of the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_LOW    = 3'd0,
        CFG_PATTERN_HIGH   = 3'd1,
        CFG_CARE_MASK      = 3'd2,
        CFG_PATTERN_LENGTH = 3'd3,
        CFG_ALIGNMENT_16   = 3'd4,
        CFG_BASE_PHASE     = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [63:0]         pattern_low;
        logic [63:0]         pattern_high;
        logic [15:0]         care_mask;
        logic [LEN_W-1:0]    pattern_length;
        logic                alignment_16;
        logic [3:0]          base_phase;
    } cfg_t;

    // window depth follows the signature cap
    function automatic int win_depth(input int max_pattern);
        return (max_pattern < SIG_BYTES) ? max_pattern : SIG_BYTES;
    endfunction

    function automatic int idx_width(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

// File: src/wbps_cfg.sv
module wbps_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [wbps_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]     cfg_data,
    output wbps_pkg::cfg_t                      cfg
);
    import wbps_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_PATTERN_LOW:    cfg_next.pattern_low    = cfg_data;
                CFG_PATTERN_HIGH:   cfg_next.pattern_high   = cfg_data;
                CFG_CARE_MASK:      cfg_next.care_mask      = cfg_data[15:0];
                CFG_PATTERN_LENGTH: cfg_next.pattern_length = cfg_data[LEN_W-1:0];
                CFG_ALIGNMENT_16:   cfg_next.alignment_16   = cfg_data[0];
                CFG_BASE_PHASE:     cfg_next.base_phase     = cfg_data[3:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg                <= '0;
            cfg_reg.pattern_length <= LEN_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: src/wbps_match.sv
module wbps_match #(
    parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEFAULT
) (
    input  wbps_pkg::cfg_t                                      cfg,
    input  logic [wbps_pkg::win_depth(MAX_PATTERN)-1:0][7:0]    window,
    output logic [wbps_pkg::LEN_W-1:0]                          eff_len,
    output logic                                                hit
);
    import wbps_pkg::*;

    localparam int WIN   = win_depth(MAX_PATTERN);
    localparam int IDX_W = idx_width(WIN);
    localparam logic [LEN_W-1:0] CAP = LEN_W'(WIN);

    logic [127:0]    sig_bytes;
    logic [WIN-1:0]  byte_ok;

    assign sig_bytes = {cfg.pattern_high, cfg.pattern_low};

    // zero counts as one, above the cap saturates
    always_comb
    begin
        if (cfg.pattern_length == '0)
            eff_len = LEN_W'(1);
        else if (cfg.pattern_length > CAP)
            eff_len = CAP;
        else
            eff_len = cfg.pattern_length;
    end

    // signature byte k lines up with window entry len-1-k
    always_comb
    begin
        logic [LEN_W-1:0] idx;
        for (int k = 0; k < WIN; k++)
        begin
            idx = eff_len - LEN_W'(1) - LEN_W'(k);
            if (cfg.care_mask[k] && (eff_len > LEN_W'(k)))
                byte_ok[k] = (window[idx[IDX_W-1:0]] == sig_bytes[8*k +: 8]);
            else
                byte_ok[k] = 1'b1;
        end
    end

    assign hit = &byte_ok;

endmodule

// File: src/wildcard_byte_pattern_scanner.sv
// channel   | handshake           | payload
// ----------+---------------------+------------------------------------------
// input     | in_valid / in_stall | data_byte, end_of_region
// output    | out_valid/out_stall | match_found, match_offset, region_done
// config    | cfg_write           | cfg_index, cfg_data (no read-back)
//
// one byte per cycle unless a held result stalls the input: a request is held
// in the input register, the window compare runs from there into the result register
// reset clears the byte count, match flag, offset, both valids and the config, but sets the pattern length to one;
// the window itself is left as is and never compared before it is filled
// a held result stalls the input only when the byte in flight would make
// another result; bytes that make none keep flowing
module wildcard_byte_pattern_scanner #(
    parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEFAULT,
    parameter int OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          data_byte,
    input  logic                                end_of_region,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                match_found,
    output logic [wbps_pkg::OFFSET_OUT_W-1:0]   match_offset,
    output logic                                region_done,
    input  logic                                cfg_write,
    input  logic [wbps_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import wbps_pkg::*;

    localparam int WIN = win_depth(MAX_PATTERN);

    cfg_t cfg;

    // input register
    logic                   s1_valid_reg;
    logic [7:0]             s1_byte_reg;
    logic                   s1_last_reg;

    // region state
    logic [7:0]             window_reg [WIN];
    logic [OFFSET_BITS-1:0] count_reg;
    logic [OFFSET_BITS-1:0] count_next;
    logic                   matched_reg;
    logic                   matched_next;
    logic [OFFSET_OUT_W-1:0] found_reg;
    logic [OFFSET_OUT_W-1:0] found_next;

    // result register
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   out_found_reg;
    logic [OFFSET_OUT_W-1:0] out_offset_reg;
    logic                   out_done_reg;

    logic [WIN-1:0][7:0]    win_cur;
    logic [LEN_W-1:0]       eff_len;
    logic                   hit;

    logic                   not_sat;
    logic [OFFSET_BITS-1:0] count_inc;
    logic [OFFSET_BITS-1:0] start;
    logic [OFFSET_BITS+OFFSET_OUT_W-1:0] start_wide;
    logic [OFFSET_OUT_W-1:0] start_out;
    logic                   len_ok;
    logic                   aligned;
    logic                   new_match;
    logic                   emit;
    logic                   s1_go;
    logic                   process;
    logic                   accept;

    wbps_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // window as it stands once the current byte has shifted in
    always_comb
    begin
        win_cur[0] = s1_byte_reg;
        for (int j = 1; j < WIN; j++)
        begin
            win_cur[j] = window_reg[j-1];
        end
    end

    wbps_match #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_match (
        .cfg     (cfg),
        .window  (win_cur),
        .eff_len (eff_len),
        .hit     (hit)
    );

    // candidate start is count + 1 - len, only once len bytes have arrived
    assign not_sat    = (count_reg != '1);
    assign count_inc  = count_reg + OFFSET_BITS'(1);
    assign len_ok     = (count_inc >= OFFSET_BITS'(eff_len));
    assign start      = count_inc - OFFSET_BITS'(eff_len);
    assign start_wide = {{OFFSET_OUT_W{1'b0}}, start};
    assign start_out  = start_wide[OFFSET_OUT_W-1:0];
    assign aligned    = ((cfg.base_phase + start[3:0]) == 4'd0);

    assign new_match = not_sat && !matched_reg && len_ok
                       && (!cfg.alignment_16 || aligned) && hit;
    assign emit      = new_match || s1_last_reg;

    // the byte in flight moves on unless it makes a result that cannot land
    assign s1_go    = !emit || !out_valid_reg || !out_stall;
    assign process  = s1_valid_reg && s1_go;
    assign in_stall = s1_valid_reg && !s1_go;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        count_next   = count_reg;
        matched_next = matched_reg;
        found_next   = found_reg;
        if (process)
        begin
            if (s1_last_reg)
            begin
                count_next   = '0;
                matched_next = 1'b0;
                found_next   = '0;
            end
            else
            begin
                if (not_sat)
                    count_next = count_inc;
                if (new_match)
                begin
                    matched_next = 1'b1;
                    found_next   = start_out;
                end
            end
        end
    end

    always_comb
    begin
        if (process && emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            count_reg     <= '0;
            matched_reg   <= 1'b0;
            found_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (process)
                s1_valid_reg <= 1'b0;
            count_reg     <= count_next;
            matched_reg   <= matched_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= end_of_region;
        end
        if (process)
        begin
            for (int j = 0; j < WIN; j++)
            begin
                window_reg[j] <= win_cur[j];
            end
        end
        if (process && emit)
        begin
            out_found_reg  <= matched_reg || new_match;
            out_offset_reg <= new_match ? start_out : found_reg;
            out_done_reg   <= s1_last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign match_found  = out_found_reg;
    assign match_offset = out_offset_reg;
    assign region_done  = out_done_reg;

endmodule
